>>> design/hbw_pkg.sv
// Package for the multi-channel heartbeat watchdog.
// Holds the command, event, status and controller state codes plus the beat structs.
// No dependencies; used by the top level of the block.
package hbw_pkg;

	// Events returned by one tick at most
	localparam int unsigned MAX_EVENTS = 32;
	// Reset value of the default reload register
	localparam logic [15:0] DEFAULT_RELOAD_RST = 16'd100;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_REG   = 2'd1,
		CMD_KICK  = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_OFFLINE = 2'd1,
		EV_REMIND  = 2'd2,
		EV_RECOVER = 2'd3
	} ev_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_UNUSED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REG,
		S_KQ,
		S_TICK,
		S_EMIT,
		S_EMIT_RD,
		S_EMIT_OUT
	} state_t;

	// Request beat
	typedef struct packed {
		logic [1:0]  cmd;
		logic [4:0]  slot_index;
		logic [15:0] reload_setting;
		logic [15:0] initial_setting;
		logic [15:0] remind_setting;
	} req_t;

	// Response beat
	typedef struct packed {
		logic [1:0]  event_kind;
		logic [4:0]  slot_number;
		logic        all_alive;
		logic        slot_online;
		logic [15:0] remaining_count;
		logic [1:0]  status;
		logic        last;
	} rsp_t;

endpackage

>>> design/hbw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for the slot table and the tick event buffer.
module hbw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/multi_channel_heartbeat_watchdog.sv
// Top level of the multi-channel heartbeat watchdog: controller, slot flags, output register.
// Depends on hbw_pkg and hbw_ram (slot table and tick event buffer).
//
//  channel  | signals                      | dir | beat
//  ---------+------------------------------+-----+----------------------------------
//  req      | req_valid, req_ready, req    | in  | one command (tick/reg/kick/query)
//  rsp      | rsp_valid, rsp_ready, rsp    | out | one result; last marks the final one
//  cfg      | cfg_we, cfg_data             | in  | default reload write, no handshake
//
// One command at a time. Register walks the used flags for the first free slot, one
// slot a cycle. A tick walks the slot table through its single read port, then reads
// each event back from the event buffer. Reset clears the slot flags and sets the
// default reload to 100; the table itself needs no clearing. A stalled rsp holds the
// controller at its output step; req_ready is high whenever the controller is idle,
// even with a result pending.
module multi_channel_heartbeat_watchdog #(
	parameter int unsigned SLOTS      = 32,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  hbw_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output hbw_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_data
);

	localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW  = $clog2(SLOTS + 1);
	localparam int unsigned IW  = (SW > 5) ? SW : 5;
	localparam int unsigned CB  = COUNT_BITS;
	localparam int unsigned NW  = $clog2(hbw_pkg::MAX_EVENTS + 1);
	localparam int unsigned EAW = $clog2(hbw_pkg::MAX_EVENTS);
	localparam int unsigned EW  = 2 + SW;

	typedef struct packed {
		logic [CB-1:0] reload;
		logic [CB-1:0] count;
		logic [CB-1:0] rperiod;
		logic [CB-1:0] rleft;
	} ent_t;

	typedef struct packed {
		logic [1:0]    kind;
		logic [SW-1:0] slot;
	} evt_t;

	// Slot index to the 5-bit result field
	function automatic logic [4:0] slot5(input logic [SW-1:0] s);
		logic [IW-1:0] w;
		w = IW'(s);
		return w[4:0];
	endfunction

	hbw_pkg::state_t state_q, state_d;
	hbw_pkg::req_t   req_q;
	hbw_pkg::rsp_t   rsp_q, rsp_d;
	logic            rsp_valid_q, rsp_load;
	logic [15:0]     default_q;
	logic [CW-1:0]   ptr_q, ptr_d;
	logic            s1_valid_q, s1_valid_d;
	logic [SW-1:0]   s1_idx_q;
	logic            all_q;
	logic [NW-1:0]   evn_q;
	logic [NW-1:0]   eptr_q, eptr_d;
	logic            ok_q;

	logic            used_q [SLOTS];
	logic            on_q   [SLOTS];
	logic [1:0]      pk_q   [SLOTS];

	// Table RAM ports
	logic            tbl_we;
	logic [SW-1:0]   tbl_waddr, tbl_raddr;
	ent_t            tbl_wdata, tbl_rdata;

	// Event buffer ports
	logic            evb_we;
	logic [EAW-1:0]  evb_waddr, evb_raddr;
	evt_t            evb_wdata, evb_rdata;

	// Decoded request
	logic [IW-1:0]   req_idx_w;
	logic [SW-1:0]   req_slot, kq_slot;
	logic            req_ok;
	logic            rsp_free;

	// Tick stage results
	logic            tk_act, tk_on, tk_push;
	logic [1:0]      tk_pk;
	logic [1:0]      tk_ev;
	ent_t            tk_ent;

	// Flag update strobes
	logic            reg_fire, kick_fire;
	logic            reg_online;
	logic [SW-1:0]   ptr_slot;
	ent_t            reg_ent;

	hbw_ram #(
		.WIDTH($bits(ent_t)),
		.DEPTH(SLOTS)
	) u_tbl (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	hbw_ram #(
		.WIDTH(EW),
		.DEPTH(hbw_pkg::MAX_EVENTS)
	) u_evb (
		.clk  (clk),
		.we   (evb_we),
		.waddr(evb_waddr),
		.wdata(evb_wdata),
		.raddr(evb_raddr),
		.rdata(evb_rdata)
	);

	assign req_idx_w = IW'(req.slot_index);
	assign req_slot  = req_idx_w[SW-1:0];
	assign req_ok    = (32'(req.slot_index) < SLOTS) && used_q[req_slot];
	assign kq_slot   = s1_idx_q;
	assign ptr_slot  = ptr_q[SW-1:0];
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == hbw_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Tick stage: count down one slot read from the table last cycle
	always_comb begin
		logic [CB-1:0] cd;
		logic [CB-1:0] rl;
		logic          on;
		logic [1:0]    pk;
		cd = tbl_rdata.count;
		rl = tbl_rdata.rleft;
		on = on_q[s1_idx_q];
		pk = pk_q[s1_idx_q];
		if (cd != '0) begin
			cd = cd - 1'b1;
			if (cd == '0 && on) begin
				on = 1'b0;
				rl = tbl_rdata.rperiod;
				pk = hbw_pkg::EV_OFFLINE;
			end
		end else if (!on && tbl_rdata.rperiod != '0) begin
			if (rl != '0) begin
				rl = rl - 1'b1;
			end
			if (rl == '0) begin
				pk = hbw_pkg::EV_REMIND;
				rl = tbl_rdata.rperiod;
			end
		end
		tk_act  = (state_q == hbw_pkg::S_TICK) && s1_valid_q && used_q[s1_idx_q];
		tk_push = tk_act && (pk != hbw_pkg::EV_NONE) && (evn_q < NW'(hbw_pkg::MAX_EVENTS));
		tk_ev   = pk;
		tk_pk   = tk_push ? hbw_pkg::EV_NONE : pk;
		tk_on   = on;
		tk_ent  = '{reload: tbl_rdata.reload, count: cd, rperiod: tbl_rdata.rperiod, rleft: rl};
	end

	// Registration entry from the captured request
	always_comb begin
		logic [CB-1:0] rl;
		logic [CB-1:0] init;
		rl = CB'(req_q.reload_setting);
		if (rl == '0) begin
			rl = CB'(default_q);
		end
		init = CB'(req_q.initial_setting);
		if (init == '0) begin
			init = rl;
		end
		reg_online = (init != '0);
		reg_ent = '{reload: rl, count: init, rperiod: CB'(req_q.remind_setting),
			rleft: CB'(req_q.remind_setting)};
	end

	// Event buffer write during the walk
	assign evb_we    = tk_push;
	assign evb_waddr = evn_q[EAW-1:0];
	assign evb_wdata = '{kind: tk_ev, slot: s1_idx_q};

	// Controller: next state, RAM ports and response
	always_comb begin
		state_d    = state_q;
		ptr_d      = ptr_q;
		eptr_d     = eptr_q;
		s1_valid_d = 1'b0;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		tbl_we     = 1'b0;
		tbl_waddr  = s1_idx_q;
		tbl_wdata  = tk_ent;
		tbl_raddr  = s1_idx_q;
		evb_raddr  = eptr_q[EAW-1:0];
		reg_fire   = 1'b0;
		kick_fire  = 1'b0;
		case (state_q)
			hbw_pkg::S_IDLE: begin
				tbl_raddr = req_slot;
				ptr_d     = '0;
				eptr_d    = '0;
				if (req_valid) begin
					case (req.cmd)
						hbw_pkg::CMD_TICK:  state_d = hbw_pkg::S_TICK;
						hbw_pkg::CMD_REG:   state_d = hbw_pkg::S_REG;
						default:            state_d = hbw_pkg::S_KQ;
					endcase
				end
			end
			hbw_pkg::S_REG: begin
				if (ptr_q == CW'(SLOTS)) begin
					if (rsp_free) begin
						rsp_load        = 1'b1;
						rsp_d.status    = hbw_pkg::ST_FULL;
						rsp_d.last      = 1'b1;
						state_d         = hbw_pkg::S_IDLE;
					end
				end else if (used_q[ptr_slot]) begin
					ptr_d = ptr_q + 1'b1;
				end else if (rsp_free) begin
					reg_fire          = 1'b1;
					tbl_we            = 1'b1;
					tbl_waddr         = ptr_slot;
					tbl_wdata         = reg_ent;
					rsp_load          = 1'b1;
					rsp_d.slot_number = slot5(ptr_slot);
					rsp_d.last        = 1'b1;
					state_d           = hbw_pkg::S_IDLE;
				end
			end
			hbw_pkg::S_KQ: begin
				tbl_raddr = kq_slot;
				if (rsp_free) begin
					rsp_load          = 1'b1;
					rsp_d.slot_number = req_q.slot_index;
					rsp_d.last        = 1'b1;
					state_d           = hbw_pkg::S_IDLE;
					if (!ok_q) begin
						rsp_d.status = hbw_pkg::ST_UNUSED;
					end else if (req_q.cmd == hbw_pkg::CMD_KICK) begin
						kick_fire = 1'b1;
						tbl_we    = 1'b1;
						tbl_waddr = kq_slot;
						tbl_wdata = '{reload: tbl_rdata.reload, count: tbl_rdata.reload,
							rperiod: tbl_rdata.rperiod, rleft: tbl_rdata.rperiod};
					end else begin
						rsp_d.slot_online     = on_q[kq_slot];
						rsp_d.remaining_count = 16'(tbl_rdata.count);
					end
				end
			end
			hbw_pkg::S_TICK: begin
				// read slot ptr while slot s1 is updated and written back
				tbl_raddr = ptr_slot;
				tbl_we    = tk_act;
				if (ptr_q != CW'(SLOTS)) begin
					s1_valid_d = 1'b1;
					ptr_d      = ptr_q + 1'b1;
				end else if (!s1_valid_q) begin
					state_d = hbw_pkg::S_EMIT;
				end
			end
			hbw_pkg::S_EMIT: begin
				if (evn_q != '0) begin
					state_d = hbw_pkg::S_EMIT_RD;
				end else if (rsp_free) begin
					rsp_load         = 1'b1;
					rsp_d.all_alive  = all_q;
					rsp_d.last       = 1'b1;
					state_d          = hbw_pkg::S_IDLE;
				end
			end
			hbw_pkg::S_EMIT_RD: begin
				state_d = hbw_pkg::S_EMIT_OUT;
			end
			hbw_pkg::S_EMIT_OUT: begin
				if (rsp_free) begin
					rsp_load          = 1'b1;
					rsp_d.event_kind  = evb_rdata.kind;
					rsp_d.slot_number = slot5(evb_rdata.slot);
					rsp_d.all_alive   = all_q;
					rsp_d.last        = (eptr_q == evn_q - 1'b1);
					eptr_d            = eptr_q + 1'b1;
					state_d           = rsp_d.last ? hbw_pkg::S_IDLE : hbw_pkg::S_EMIT_RD;
				end
			end
			default: begin
				state_d = hbw_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hbw_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
			default_q   <= hbw_pkg::DEFAULT_RELOAD_RST;
			ptr_q       <= '0;
			eptr_q      <= '0;
			s1_valid_q  <= 1'b0;
			all_q       <= 1'b1;
			evn_q       <= '0;
		end else begin
			state_q    <= state_d;
			ptr_q      <= ptr_d;
			eptr_q     <= eptr_d;
			s1_valid_q <= s1_valid_d;
			if (cfg_we) begin
				default_q <= cfg_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == hbw_pkg::S_IDLE) begin
				all_q <= 1'b1;
				evn_q <= '0;
			end else begin
				if (tk_act && !tk_on) begin
					all_q <= 1'b0;
				end
				if (tk_push) begin
					evn_q <= evn_q + 1'b1;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		if (state_q == hbw_pkg::S_IDLE) begin
			req_q <= req;
			ok_q  <= req_ok;
		end
		if (state_q == hbw_pkg::S_IDLE) begin
			s1_idx_q <= req_slot;
		end else if (state_q == hbw_pkg::S_TICK) begin
			s1_idx_q <= ptr_slot;
		end
	end

	// Slot flags: used, online, pending event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				used_q[i] <= 1'b0;
				on_q[i]   <= 1'b0;
				pk_q[i]   <= hbw_pkg::EV_NONE;
			end
		end else begin
			if (tk_act) begin
				on_q[s1_idx_q] <= tk_on;
				pk_q[s1_idx_q] <= tk_pk;
			end
			if (reg_fire) begin
				used_q[ptr_slot] <= 1'b1;
				on_q[ptr_slot]   <= reg_online;
				pk_q[ptr_slot]   <= hbw_pkg::EV_NONE;
			end
			if (kick_fire && !on_q[kq_slot]) begin
				on_q[kq_slot] <= 1'b1;
				pk_q[kq_slot] <= hbw_pkg::EV_RECOVER;
			end
		end
	end

endmodule
